>>> src/ftfi_pkg.sv
// Shared types and constants for the fraction to Farey interval block.
// Used by the controller, the datapath and the top level.
package ftfi_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned FieldW   = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_RED_N,
    ST_RED_D,
    ST_WALK,
    ST_WALK_DIV,
    ST_WALK_MUL,
    ST_DONE
  } ftfi_state_t;

  // divider operand selection
  typedef enum logic [2:0] {
    DSEL_GCD,
    DSEL_RED_N,
    DSEL_RED_D,
    DSEL_WALK_X,
    DSEL_WALK_Y
  } ftfi_dsel_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    ftfi_dsel_t dsel;
    logic       gcd_step;
    logic       red_n;
    logic       red_d;
    logic       walk_init;
    logic       walk_mul;
    logic       publish;
  } ftfi_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic div_busy;
    logic gcd_done;
    logic walk_done;
    logic x_gt_y;
  } ftfi_sts_t;

endpackage

>>> src/fraction_to_farey_interval_top.sv
// Top level of the fraction to Farey interval block.
// Depends on ftfi_pkg, ftfi_ctrl, ftfi_datapath.
//
// Usage: present in_numerator/in_denominator with in_valid; the item is
// taken when in_stall is low. The block reduces the fraction by its GCD
// (Euclid, one division per remainder step), then walks the Stern-Brocot
// tree one run per division, each run length a quotient, less one when
// the division is exact. Every division runs in the shared restoring
// divider, and each GCD step or run adds the control states CHECK and
// GCD_STEP, or WALK and WALK_MUL. One item is in flight at a time. The
// result waits in an output register with out_valid high while out_stall
// is high; the next item is accepted as soon as a result enters that
// register, and a following result that finds it still full holds in its
// final state until it is taken. A zero numerator or denominator gives
// bad_input = 1 with all other fields zero. Synchronous reset (rst_n low)
// drops any item in flight and clears out_valid.
module fraction_to_farey_interval_top import ftfi_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FieldW-1:0] in_numerator,
  input  logic [FieldW-1:0] in_denominator,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FieldW-1:0] out_left_num,
  output logic [FieldW-1:0] out_left_den,
  output logic [FieldW-1:0] out_right_num,
  output logic [FieldW-1:0] out_right_den,
  output logic [FieldW-1:0] out_reduced_num,
  output logic [FieldW-1:0] out_reduced_den,
  output logic              out_bad_input
);
  ftfi_cmd_t cmd;
  ftfi_sts_t sts;

  ftfi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ftfi_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_numerator(in_numerator), .in_denominator(in_denominator),
    .res_left_num(out_left_num), .res_left_den(out_left_den),
    .res_right_num(out_right_num), .res_right_den(out_right_den),
    .res_reduced_num(out_reduced_num), .res_reduced_den(out_reduced_den),
    .res_bad_input(out_bad_input)
  );
endmodule

>>> src/ftfi_div.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on nothing but its parameter.
module ftfi_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);
  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [WIDTH:0]   trial;

  // shift in one dividend bit, try a subtract
  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    trial = {r_r, q_r[WIDTH-1]} - {1'b0, d_r};
    if (start) begin
      cnt_nxt = CntW'(WIDTH);
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[WIDTH]) begin
        r_nxt = trial[WIDTH-1:0];
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WIDTH-2:0], q_r[WIDTH-1]};
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem  = r_r;
endmodule

>>> src/ftfi_datapath.sv
// Datapath: operand registers, shared divider, walk bounds and result register.
// Depends on ftfi_pkg and ftfi_div.
module ftfi_datapath import ftfi_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ftfi_cmd_t         cmd,
  output ftfi_sts_t         sts,
  input  logic [FieldW-1:0] in_numerator,
  input  logic [FieldW-1:0] in_denominator,
  output logic [FieldW-1:0] res_left_num,
  output logic [FieldW-1:0] res_left_den,
  output logic [FieldW-1:0] res_right_num,
  output logic [FieldW-1:0] res_right_den,
  output logic [FieldW-1:0] res_reduced_num,
  output logic [FieldW-1:0] res_reduced_den,
  output logic              res_bad_input
);
  logic [WIDTH-1:0] n_r, d_r, a_r, b_r, x_r, y_r, k_r;
  logic [WIDTH-1:0] lp_r, lq_r, rp_r, rq_r;
  logic [WIDTH-1:0] dvd, dvs, quot, rem, kk;
  logic             busy;

  ftfi_div #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dvd), .divisor(dvs), .busy(busy), .quot(quot), .rem(rem)
  );

  // pick divider operands
  always_comb begin
    unique case (cmd.dsel)
      DSEL_GCD:    begin dvd = a_r; dvs = b_r; end
      DSEL_RED_N:  begin dvd = n_r; dvs = a_r; end
      DSEL_RED_D:  begin dvd = d_r; dvs = a_r; end
      DSEL_WALK_X: begin dvd = x_r; dvs = y_r; end
      DSEL_WALK_Y: begin dvd = y_r; dvs = x_r; end
      default:     begin dvd = a_r; dvs = b_r; end
    endcase
  end

  // run length: quotient, less one on exact division
  assign kk = (rem == '0) ? quot - 1'b1 : quot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_numerator[WIDTH-1:0];
      d_r <= in_denominator[WIDTH-1:0];
      a_r <= in_numerator[WIDTH-1:0];
      b_r <= in_denominator[WIDTH-1:0];
    end
    if (cmd.gcd_step) begin
      a_r <= b_r;
      b_r <= rem;
    end
    if (cmd.red_n) n_r <= quot;
    if (cmd.red_d) d_r <= quot;
    // start the walk; the reduced denominator arrives at this same edge
    if (cmd.walk_init) begin
      x_r <= n_r; y_r <= cmd.red_d ? quot : d_r;
      lp_r <= '0; lq_r <= WIDTH'(1);
      rp_r <= WIDTH'(1); rq_r <= '0;
    end
    // latch run length after the division
    if (cmd.div_start) k_r <= '0;
    else if (!busy && (cmd.dsel == DSEL_WALK_X || cmd.dsel == DSEL_WALK_Y)) k_r <= kk;
    // advance one run: x -= y*k, left += right*k (or mirrored)
    if (cmd.walk_mul) begin
      if (x_r > y_r) begin
        lp_r <= lp_r + rp_r * k_r;
        lq_r <= lq_r + rq_r * k_r;
        x_r  <= x_r - y_r * k_r;
      end else begin
        rp_r <= rp_r + lp_r * k_r;
        rq_r <= rq_r + lq_r * k_r;
        y_r  <= y_r - x_r * k_r;
      end
    end
    if (cmd.publish) begin
      if (n_r == '0 || d_r == '0) begin
        res_left_num <= '0; res_left_den <= '0;
        res_right_num <= '0; res_right_den <= '0;
        res_reduced_num <= '0; res_reduced_den <= '0;
        res_bad_input <= 1'b1;
      end else begin
        res_left_num    <= FieldW'(lp_r);
        res_left_den    <= FieldW'(lq_r);
        res_right_num   <= FieldW'(rp_r);
        res_right_den   <= FieldW'(rq_r);
        res_reduced_num <= FieldW'(n_r);
        res_reduced_den <= FieldW'(d_r);
        res_bad_input   <= 1'b0;
      end
    end
  end

  assign sts.zero_in   = (n_r == '0) || (d_r == '0);
  assign sts.div_busy  = busy;
  assign sts.gcd_done  = (b_r == '0);
  assign sts.walk_done = (x_r == y_r);
  assign sts.x_gt_y    = (x_r > y_r);
endmodule

>>> src/ftfi_ctrl.sv
// Controller: sequences GCD, reduction and the tree walk; owns the handshakes.
// Depends on ftfi_pkg.
module ftfi_ctrl import ftfi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ftfi_sts_t sts,
  output ftfi_cmd_t cmd
);
  ftfi_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;
  logic        pub;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = sts.zero_in ? ST_DONE :
                               (sts.gcd_done ? ST_RED_N : ST_GCD_DIV);
      ST_GCD_DIV:  if (!sts.div_busy) state_nxt = ST_GCD_STEP;
      ST_GCD_STEP: state_nxt = ST_CHECK;
      ST_RED_N:    if (!sts.div_busy) state_nxt = ST_RED_D;
      ST_RED_D:    if (!sts.div_busy) state_nxt = ST_WALK;
      ST_WALK:     state_nxt = sts.walk_done ? ST_DONE : ST_WALK_DIV;
      ST_WALK_DIV: if (!sts.div_busy) state_nxt = ST_WALK_MUL;
      ST_WALK_MUL: state_nxt = ST_WALK;
      ST_DONE:     if (!ov_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.dsel = DSEL_GCD;
    unique case (state_r)
      ST_IDLE:     cmd.load = in_valid;
      ST_CHECK:    begin
        cmd.div_start = !sts.zero_in;
        cmd.dsel = sts.gcd_done ? DSEL_RED_N : DSEL_GCD;
      end
      ST_GCD_DIV:  cmd.dsel = DSEL_GCD;
      ST_GCD_STEP: cmd.gcd_step = 1'b1;
      ST_RED_N:    begin
        // take the reduced numerator, start the denominator division
        cmd.dsel = DSEL_RED_D;
        cmd.red_n = !sts.div_busy;
        cmd.div_start = !sts.div_busy;
      end
      ST_RED_D:    begin
        cmd.dsel = DSEL_RED_D;
        cmd.red_d = !sts.div_busy;
        cmd.walk_init = !sts.div_busy;
      end
      ST_WALK:     begin
        cmd.dsel = sts.x_gt_y ? DSEL_WALK_X : DSEL_WALK_Y;
        cmd.div_start = !sts.walk_done;
      end
      ST_WALK_DIV: cmd.dsel = sts.x_gt_y ? DSEL_WALK_X : DSEL_WALK_Y;
      ST_WALK_MUL: cmd.walk_mul = 1'b1;
      ST_DONE:     cmd.publish = !ov_r || !out_stall;
      default:     cmd = '0;
    endcase
  end

  assign pub = cmd.publish;

  // hold result valid until taken
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (pub) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;
endmodule
